/* hdl/ipc_pkg.sv */
package ipc_pkg;

   // input item: one character of the infix expression, or the end mark
   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_expr;
   } req_type;

   // result item: a postfix character or the final status
   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       last;
   } rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_CLASSIFY,
      S_CLOSE,
      S_OPER,
      S_POP_SPACE,
      S_END_SPACE,
      S_FLUSH,
      S_STATUS,
      S_FINISH
   } seq_state_type;

   // result kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_PAREN   = 3'd1;
   localparam logic [2:0] ERR_UNKNOWN = 3'd2;
   localparam logic [2:0] ERR_FULL    = 3'd3;
   localparam logic [2:0] ERR_LONG    = 3'd4;

   // stack entry codes
   localparam logic [2:0] OP_LPAREN = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_POW    = 3'd5;

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_CARET  = 8'h5e;

   // register map
   localparam logic REG_OUTPUT_LIMIT = 1'b0;
   localparam logic [12:0] LIMIT_RESET = 13'd1024;

   // operator code of a character, open paren code when not an operator
   function automatic logic [2:0] op_code_of(input logic [7:0] c);
      logic [2:0] code;
      case (c)
         CH_PLUS:  code = OP_ADD;
         CH_MINUS: code = OP_SUB;
         CH_STAR:  code = OP_MUL;
         CH_SLASH: code = OP_DIV;
         CH_CARET: code = OP_POW;
         default:  code = OP_LPAREN;
      endcase
      return code;
   endfunction

   // binding strength of a stack entry
   function automatic logic [1:0] op_prec(input logic [2:0] code);
      logic [1:0] prec;
      case (code)
         OP_ADD, OP_SUB: prec = 2'd1;
         OP_MUL, OP_DIV: prec = 2'd2;
         OP_POW:         prec = 2'd3;
         default:        prec = 2'd0;
      endcase
      return prec;
   endfunction

   // character of a stack entry
   function automatic logic [7:0] op_char(input logic [2:0] code);
      logic [7:0] c;
      case (code)
         OP_LPAREN: c = CH_LPAREN;
         OP_ADD:    c = CH_PLUS;
         OP_SUB:    c = CH_MINUS;
         OP_MUL:    c = CH_STAR;
         OP_DIV:    c = CH_SLASH;
         OP_POW:    c = CH_CARET;
         default:   c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

/* hdl/infix_to_postfix_converter.sv */
// Shunting-yard infix to postfix converter. One character arrives per item, and an item
// with end_of_expr set closes the expression and always yields exactly one status item
// (accepted, or rejected with an error code) as its last result. A small sequencer walks
// each item and, unless the result side stalls, hands out one result per cycle through a
// holding register, which lets it mark the final result of an item with last, and then an
// output register. Every operator popped from the stack yields its character and a
// separating space, and once the expression has failed any item other than the end mark
// yields no result. The operator stack is a STACK_DEPTH-entry memory with a registered
// read of its top entry; it holds at most STACK_DEPTH-1 operators. output_limit is written
// through the register port at address 0 and should only change between expressions.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipc_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ipc_pkg::*;

   localparam int CW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CW-1:0] STACK_MAX = CW'(STACK_DEPTH - 1);

   // control registers
   seq_state_type state_ff, state_in;
   seq_state_type ret_ff, ret_in;
   logic [CW-1:0] count_ff, count_in;
   logic          in_number_ff, in_number_in;
   logic [12:0]   emitted_ff, emitted_in;
   logic          failed_ff, failed_in;
   logic [2:0]    fail_code_ff, fail_code_in;
   logic [12:0]   limit_ff, limit_in;
   logic          hold_valid_ff, hold_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]    char_ff, char_in;
   logic          end_ff, end_in;
   rsp_type       hold_ff, hold_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic [2:0]    top_rd_ff;

   // operator stack
   logic [2:0]    stack_mem [STACK_DEPTH];
   logic [CW-1:0] rd_idx;

   // sequencer helpers
   logic          out_free;
   logic          can_emit;
   logic          emit_en;
   rsp_type       emit_item;
   logic          flush_en;
   logic          push_en;
   logic [2:0]    push_code;
   logic          fits1;
   logic          fits2;
   logic          is_digit;
   logic          is_white;
   logic [2:0]    oper_code;
   logic          pop_it;
   logic          cfg_write;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   // register port
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_LIMIT);
   assign limit_in  = cfg_write ? pwdata[12:0] : limit_ff;
   assign prdata    = (paddr[2] == REG_OUTPUT_LIMIT) ? {19'd0, limit_ff} : 32'd0;

   // character classes and limit checks
   assign is_digit  = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign is_white  = (char_ff == CH_SPACE) || ((char_ff >= CH_TAB) && (char_ff <= CH_CR));
   assign oper_code = op_code_of(char_ff);
   assign pop_it    = (oper_code == OP_POW) ? (op_prec(top_rd_ff) > op_prec(oper_code))
                                            : (op_prec(top_rd_ff) >= op_prec(oper_code));
   assign fits1     = ({1'b0, emitted_ff} + 14'd1) < {1'b0, limit_ff};
   assign fits2     = ({1'b0, emitted_ff} + 14'd2) < {1'b0, limit_ff};
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_emit  = !hold_valid_ff || out_free;
   assign rd_idx    = (count_ff == '0) ? '0 : count_ff - CW'(1);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      count_in     = count_ff;
      in_number_in = in_number_ff;
      emitted_in   = emitted_ff;
      failed_in    = failed_ff;
      fail_code_in = fail_code_ff;
      char_in      = char_ff;
      end_in       = end_ff;
      emit_en      = 1'b0;
      emit_item    = '{out_char: CH_NUL, kind: KIND_CHAR, error_code: ERR_NONE, last: 1'b0};
      flush_en     = 1'b0;
      push_en      = 1'b0;
      push_code    = OP_LPAREN;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in  = req_data.in_char;
               end_in   = req_data.end_of_expr;
               state_in = S_START;
            end
         end

         S_START: begin
            if (end_ff) begin
               state_in = (!failed_ff && in_number_ff) ? S_END_SPACE : S_FLUSH;
            end else if (failed_ff) begin
               state_in = S_FINISH;
            end else if (is_digit) begin
               in_number_in = 1'b1;
               if (!fits1) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_LONG;
                  state_in     = S_FINISH;
               end else if (can_emit) begin
                  emit_en            = 1'b1;
                  emit_item.out_char = char_ff;
                  emitted_in         = emitted_ff + 13'd1;
                  state_in           = S_FINISH;
               end
            end else if (in_number_ff) begin
               // a run of digits ends with a space
               if (!fits1) begin
                  in_number_in = 1'b0;
                  failed_in    = 1'b1;
                  fail_code_in = ERR_LONG;
                  state_in     = S_FINISH;
               end else if (can_emit) begin
                  in_number_in       = 1'b0;
                  emit_en            = 1'b1;
                  emit_item.out_char = CH_SPACE;
                  emitted_in         = emitted_ff + 13'd1;
                  state_in           = S_CLASSIFY;
               end
            end else begin
               state_in = S_CLASSIFY;
            end
         end

         S_CLASSIFY: begin
            if (is_white) begin
               state_in = S_FINISH;
            end else if (char_ff == CH_LPAREN) begin
               if (count_ff >= STACK_MAX) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_FULL;
               end else begin
                  push_en   = 1'b1;
                  push_code = OP_LPAREN;
                  count_in  = count_ff + CW'(1);
               end
               state_in = S_FINISH;
            end else if (char_ff == CH_RPAREN) begin
               state_in = S_CLOSE;
            end else if (oper_code != OP_LPAREN) begin
               state_in = S_OPER;
            end else begin
               failed_in    = 1'b1;
               fail_code_in = ERR_UNKNOWN;
               state_in     = S_FINISH;
            end
         end

         // pop operators down to the matching open paren
         S_CLOSE: begin
            if (count_ff != '0 && top_rd_ff != OP_LPAREN) begin
               if (!fits2) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_LONG;
                  state_in     = S_FINISH;
               end else if (can_emit) begin
                  emit_en            = 1'b1;
                  emit_item.out_char = op_char(top_rd_ff);
                  emitted_in         = emitted_ff + 13'd1;
                  count_in           = count_ff - CW'(1);
                  ret_in             = S_CLOSE;
                  state_in           = S_POP_SPACE;
               end
            end else if (count_ff == '0) begin
               failed_in    = 1'b1;
               fail_code_in = ERR_PAREN;
               state_in     = S_FINISH;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_FINISH;
            end
         end

         // pop operators that bind at least as tightly (more tightly for ^), then push
         S_OPER: begin
            if (count_ff != '0 && top_rd_ff != OP_LPAREN && pop_it) begin
               if (!fits2) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_LONG;
                  state_in     = S_FINISH;
               end else if (can_emit) begin
                  emit_en            = 1'b1;
                  emit_item.out_char = op_char(top_rd_ff);
                  emitted_in         = emitted_ff + 13'd1;
                  count_in           = count_ff - CW'(1);
                  ret_in             = S_OPER;
                  state_in           = S_POP_SPACE;
               end
            end else begin
               if (count_ff >= STACK_MAX) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_FULL;
               end else begin
                  push_en   = 1'b1;
                  push_code = oper_code;
                  count_in  = count_ff + CW'(1);
               end
               state_in = S_FINISH;
            end
         end

         // space after a popped operator; also lets the registered top read catch up
         S_POP_SPACE: begin
            if (can_emit) begin
               emit_en            = 1'b1;
               emit_item.out_char = CH_SPACE;
               emitted_in         = emitted_ff + 13'd1;
               state_in           = ret_ff;
            end
         end

         S_END_SPACE: begin
            if (!fits1) begin
               in_number_in = 1'b0;
               failed_in    = 1'b1;
               fail_code_in = ERR_LONG;
               state_in     = S_STATUS;
            end else if (can_emit) begin
               in_number_in       = 1'b0;
               emit_en            = 1'b1;
               emit_item.out_char = CH_SPACE;
               emitted_in         = emitted_ff + 13'd1;
               state_in           = S_FLUSH;
            end
         end

         // empty the stack at the end of the expression
         S_FLUSH: begin
            if (!failed_ff && count_ff != '0) begin
               if (top_rd_ff == OP_LPAREN) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_PAREN;
                  state_in     = S_STATUS;
               end else if (!fits2) begin
                  failed_in    = 1'b1;
                  fail_code_in = ERR_LONG;
                  state_in     = S_STATUS;
               end else if (can_emit) begin
                  emit_en            = 1'b1;
                  emit_item.out_char = op_char(top_rd_ff);
                  emitted_in         = emitted_ff + 13'd1;
                  count_in           = count_ff - CW'(1);
                  ret_in             = S_FLUSH;
                  state_in           = S_POP_SPACE;
               end
            end else begin
               state_in = S_STATUS;
            end
         end

         S_STATUS: begin
            if (can_emit) begin
               emit_en = 1'b1;
               if (failed_ff) begin
                  emit_item.kind       = KIND_REJECT;
                  emit_item.error_code = fail_code_ff;
               end else begin
                  emit_item.kind = KIND_ACCEPT;
               end
               count_in     = '0;
               in_number_in = 1'b0;
               emitted_in   = '0;
               failed_in    = 1'b0;
               fail_code_in = ERR_NONE;
               state_in     = S_FINISH;
            end
         end

         // release the held item marked as last
         S_FINISH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               flush_en = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // holding register and output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (emit_en) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = hold_ff;
         end
         hold_in       = emit_item;
         hold_valid_in = 1'b1;
      end else if (flush_en) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = hold_ff;
         rsp_data_in.last = 1'b1;
         hold_valid_in    = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         count_ff      <= '0;
         in_number_ff  <= 1'b0;
         emitted_ff    <= '0;
         failed_ff     <= 1'b0;
         fail_code_ff  <= ERR_NONE;
         limit_ff      <= LIMIT_RESET;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         count_ff      <= count_in;
         in_number_ff  <= in_number_in;
         emitted_ff    <= emitted_in;
         failed_ff     <= failed_in;
         fail_code_ff  <= fail_code_in;
         limit_ff      <= limit_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      end_ff      <= end_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // operator stack, written on push, top read registered
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[count_ff] <= push_code;
      end
      top_rd_ff <= stack_mem[rd_idx];
   end

endmodule
